### sv/mwlfo_pkg.sv
// Shared constants, types and the quarter-wave sine table of the multi-waveform LFO.
package mwlfo_pkg;

    // Fixed field widths
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 32;
    localparam int LEVEL_W = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W  = 3;

    // Datapath sizing
    localparam int SINE_TABLE_BITS = 8;
    localparam int PHASE_BITS      = 32;
    localparam int SHAPE_FRAC_BITS = 16;
    localparam int SHAPE_W         = SHAPE_FRAC_BITS + 1;
    localparam int TAB_N           = 1 << SINE_TABLE_BITS;
    localparam int TAB_W           = 31;
    localparam int QB              = PHASE_BITS - 2;
    localparam int FB              = QB - SINE_TABLE_BITS;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE    = 3'd4;

    // Waveform codes
    localparam logic [MODE_W-1:0] MODE_SINE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SAW      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SQUARE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE = 3'd3;

    // Register reset values
    localparam logic [STEP_W-1:0]  RST_PHASE_STEP   = 32'd4294967;
    localparam logic [STEP_W-1:0]  RST_PHASE_OFFSET = 32'd0;
    localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL    = 28'd0;
    localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL    = 28'd65536;
    localparam logic [MODE_W-1:0]  RST_WAVE_MODE    = 3'd0;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint Q30_ONE     = 64'sd1 << 30;

    typedef logic [TAB_N:0][TAB_W-1:0] t_sine_tab;

    // Build sin(x) for x in 0..pi/2 in Q30 with a Taylor series to x^13
    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        longint    x;
        longint    x2;
        longint    term;
        longint    sum;
        for (int k = 0; k <= TAB_N; k++) begin
            x    = (HALF_PI_Q30 * longint'(k)) >>> SINE_TABLE_BITS;
            x2   = (x * x) >>> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >>> 30) / 6;
            sum  = sum - term;
            term = ((term * x2) >>> 30) / 20;
            sum  = sum + term;
            term = ((term * x2) >>> 30) / 42;
            sum  = sum - term;
            term = ((term * x2) >>> 30) / 72;
            sum  = sum + term;
            term = ((term * x2) >>> 30) / 110;
            sum  = sum - term;
            term = ((term * x2) >>> 30) / 156;
            sum  = sum + term;
            if (sum < 0) sum = 0;
            if (sum > Q30_ONE) sum = Q30_ONE;
            tab[k] = sum[TAB_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

### sv/multi_waveform_lfo.sv
// Top level of the multi-waveform LFO: config registers and a seven-stage shape/level pipeline.
// Throughput: one transaction per cycle unless the output stalls; each stage holds one item and
// a ready chain lets stages behind a stalled output keep filling, so nothing is lost or repeated.
// The stage widths are set by the 32x32 phase multiply and the shape-by-range multiply.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
module multi_waveform_lfo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] time_ticks
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [27:0] level, [44:28] shape, [47:45] zero
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int NSTG = 7;
    localparam int PB   = mwlfo_pkg::PHASE_BITS;
    localparam int SF   = mwlfo_pkg::SHAPE_FRAC_BITS;
    localparam int SW   = mwlfo_pkg::SHAPE_W;
    localparam int LW   = mwlfo_pkg::LEVEL_W;
    localparam int QB   = mwlfo_pkg::QB;
    localparam int FB   = mwlfo_pkg::FB;
    localparam int TB   = mwlfo_pkg::SINE_TABLE_BITS;
    localparam int TW   = mwlfo_pkg::TAB_W;
    localparam int MW   = TW + FB;
    localparam int DW   = LW + 1;
    localparam int PW   = SW + 1 + DW;

    localparam logic [SW-1:0] SHAPE_ONE  = SW'(1) << SF;
    localparam logic [SW-1:0] SHAPE_HALF = SW'(1) << (SF - 1);
    localparam logic [32:0]   Q30_ONE_33 = 33'd1 << 30;
    localparam logic [PB:0]   PHASE_ONE  = (PB + 1)'(1) << PB;
    localparam logic [QB:0]   QUAD_ONE   = (QB + 1)'(1) << QB;
    localparam logic signed [PW-SF:0] LEVEL_HI = (PW - SF + 1)'((64'sd1 <<< (LW - 1)) - 1);
    localparam logic signed [PW-SF:0] LEVEL_LO = -((PW - SF + 1)'(64'sd1 <<< (LW - 1)));

    // configuration registers
    logic [31:0]   r_phase_step;
    logic [31:0]   r_phase_offset;
    logic [LW-1:0] r_min_level;
    logic [LW-1:0] r_max_level;
    logic [2:0]    r_wave_mode;

    // pipeline control
    logic [NSTG:1] r_vld;
    logic [NSTG:1] stg_rdy;

    // stage payloads
    logic [PB-1:0]          r_s1_prod;
    logic [PB-1:0]          r_s2_f;
    logic [TW-1:0]          r_s3_a;
    logic [TW-1:0]          r_s3_diff;
    logic [FB-1:0]          r_s3_frac;
    logic [1:0]             r_s3_quad;
    logic [SW-1:0]          r_s3_alt;
    logic                   r_s3_sine;
    logic [MW-1:0]          r_s4_mult;
    logic [TW-1:0]          r_s4_a;
    logic [1:0]             r_s4_quad;
    logic [SW-1:0]          r_s4_alt;
    logic                   r_s4_sine;
    logic [SW-1:0]          r_s5_shape;
    logic signed [PW-1:0]   r_s6_prod;
    logic [SW-1:0]          r_s6_shape;
    logic [LW-1:0]          r_s7_level;
    logic [SW-1:0]          r_s7_shape;

    // stage 3 combinational values
    logic [1:0]     n_s3_quad;
    logic [QB-1:0]  s3_p;
    logic [QB:0]    s3_pm;
    logic [TB:0]    s3_idx;
    logic [TB:0]    s3_idx_b;
    logic [TW-1:0]  s3_tab_a;
    logic [TW-1:0]  s3_tab_b;
    logic [PB:0]    s3_two_f;
    logic [PB:0]    s3_tri;
    logic [SW-1:0]  n_s3_alt;

    // stage 5 combinational values
    logic [32:0]    s5_s;
    logic [32:0]    s5_sc;
    logic [32:0]    s5_s2;
    logic [SW-1:0]  n_s5_shape;

    // stage 6 and 7 combinational values
    logic signed [DW-1:0]   s6_range;
    logic signed [PW-SF-1:0] s7_q;
    logic signed [PW-SF:0]  s7_sum;
    logic [LW-1:0]          n_s7_level;

    // Take register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= mwlfo_pkg::RST_PHASE_STEP;
            r_phase_offset <= mwlfo_pkg::RST_PHASE_OFFSET;
            r_min_level    <= mwlfo_pkg::RST_MIN_LEVEL;
            r_max_level    <= mwlfo_pkg::RST_MAX_LEVEL;
            r_wave_mode    <= mwlfo_pkg::RST_WAVE_MODE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mwlfo_pkg::REG_PHASE_STEP:   r_phase_step   <= i_cfg_data;
                mwlfo_pkg::REG_PHASE_OFFSET: r_phase_offset <= i_cfg_data;
                mwlfo_pkg::REG_MIN_LEVEL:    r_min_level    <= i_cfg_data[LW-1:0];
                mwlfo_pkg::REG_MAX_LEVEL:    r_max_level    <= i_cfg_data[LW-1:0];
                mwlfo_pkg::REG_WAVE_MODE:    r_wave_mode    <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Ready chain: a stage loads when it is empty or its content moves on
    always_comb begin
        stg_rdy[NSTG] = !r_vld[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    assign s_axis_tready = stg_rdy[1];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[1]) r_vld[1] <= s_axis_tvalid;
            for (int k = 2; k <= NSTG; k++) begin
                if (stg_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 3: quadrant fold, table read and non-sine shapes
    always_comb begin
        n_s3_quad = r_s2_f[PB-1 -: 2];
        s3_p      = r_s2_f[QB-1:0];
        s3_pm     = n_s3_quad[0] ? (QUAD_ONE - {1'b0, s3_p}) : {1'b0, s3_p};
        s3_idx    = s3_pm[QB -: (TB + 1)];
        s3_idx_b  = s3_idx[TB] ? s3_idx : (s3_idx + (TB + 1)'(1));
        s3_tab_a  = mwlfo_pkg::SINE_TAB[s3_idx];
        s3_tab_b  = mwlfo_pkg::SINE_TAB[s3_idx_b];
        s3_two_f  = {r_s2_f, 1'b0};
        s3_tri    = r_s2_f[PB-1] ? (s3_two_f - PHASE_ONE) : (PHASE_ONE - s3_two_f);
        case (r_wave_mode)
            mwlfo_pkg::MODE_SAW:
                n_s3_alt = {1'b0, r_s2_f[PB-1 -: SF]};
            mwlfo_pkg::MODE_SQUARE:
                n_s3_alt = r_s2_f[PB-1] ? SHAPE_ONE : '0;
            mwlfo_pkg::MODE_TRIANGLE:
                n_s3_alt = s3_tri[PB -: SW];
            default:
                n_s3_alt = SHAPE_HALF;
        endcase
    end

    // Stage 5: finish the sine, pick the shape
    always_comb begin
        s5_s  = 33'(r_s4_a) + 33'(r_s4_mult >> FB);
        s5_sc = (s5_s > Q30_ONE_33) ? Q30_ONE_33 : s5_s;
        s5_s2 = r_s4_quad[1] ? (Q30_ONE_33 - s5_sc) : (Q30_ONE_33 + s5_sc);
        n_s5_shape = r_s4_sine ? s5_s2[31 -: SW] : r_s4_alt;
        if (n_s5_shape > SHAPE_ONE) n_s5_shape = SHAPE_ONE;
    end

    // Stage 6 range and stage 7 offset with saturation
    always_comb begin
        s6_range = $signed({r_max_level[LW-1], r_max_level})
                 - $signed({r_min_level[LW-1], r_min_level});
        s7_q     = r_s6_prod[PW-1:SF];
        s7_sum   = $signed({{(PW - SF + 1 - LW){r_min_level[LW-1]}}, r_min_level})
                 + $signed({s7_q[PW-SF-1], s7_q});
        if (s7_sum > LEVEL_HI)
            n_s7_level = LEVEL_HI[LW-1:0];
        else if (s7_sum < LEVEL_LO)
            n_s7_level = LEVEL_LO[LW-1:0];
        else
            n_s7_level = s7_sum[LW-1:0];
    end

    // Stage payload registers
    always_ff @(posedge i_clk) begin
        // phase product
        if (stg_rdy[1]) begin
            r_s1_prod <= PB'(64'(s_axis_tdata) * 64'(r_phase_step));
        end
        // phase fraction
        if (stg_rdy[2]) begin
            r_s2_f <= r_s1_prod + PB'(r_phase_offset);
        end
        // table entries and slope
        if (stg_rdy[3]) begin
            r_s3_a    <= s3_tab_a;
            r_s3_diff <= s3_idx[TB] ? '0 : (s3_tab_b - s3_tab_a);
            r_s3_frac <= s3_pm[FB-1:0];
            r_s3_quad <= n_s3_quad;
            r_s3_alt  <= n_s3_alt;
            r_s3_sine <= (r_wave_mode == mwlfo_pkg::MODE_SINE);
        end
        // interpolation product
        if (stg_rdy[4]) begin
            r_s4_mult <= MW'(r_s3_diff) * MW'(r_s3_frac);
            r_s4_a    <= r_s3_a;
            r_s4_quad <= r_s3_quad;
            r_s4_alt  <= r_s3_alt;
            r_s4_sine <= r_s3_sine;
        end
        // shape
        if (stg_rdy[5]) begin
            r_s5_shape <= n_s5_shape;
        end
        // shape times level range
        if (stg_rdy[6]) begin
            r_s6_prod  <= $signed({1'b0, r_s5_shape}) * s6_range;
            r_s6_shape <= r_s5_shape;
        end
        // output register
        if (stg_rdy[7]) begin
            r_s7_level <= n_s7_level;
            r_s7_shape <= r_s6_shape;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG];
    assign m_axis_tdata  = {(48 - LW - SW)'(0), r_s7_shape, r_s7_level};

endmodule

### tb/sv/lfo_wave_checker.sv
// Checker for the multi-waveform LFO: shadows the registers, predicts each sample and compares.
module lfo_wave_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_time,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     QUARTER_N   = 256;
    localparam longint UNIT_Q30    = 64'sd1 << 30;
    localparam longint HALF_PI_FIX = 64'sd1686629713;
    localparam longint LEVEL_HI    = 64'sd134217727;
    localparam longint LEVEL_LO    = -64'sd134217728;
    localparam int     PRINT_LIMIT = 40;

    typedef struct packed {
        logic [mwlfo_pkg::LEVEL_W-1:0] level;
        logic [mwlfo_pkg::SHAPE_W-1:0] shape;
    } t_lfo_sample;

    // Register shadow, loaded with the reset values
    logic [mwlfo_pkg::STEP_W-1:0]  step_r   = mwlfo_pkg::RST_PHASE_STEP;
    logic [mwlfo_pkg::STEP_W-1:0]  offset_r = mwlfo_pkg::RST_PHASE_OFFSET;
    logic [mwlfo_pkg::LEVEL_W-1:0] min_r    = mwlfo_pkg::RST_MIN_LEVEL;
    logic [mwlfo_pkg::LEVEL_W-1:0] max_r    = mwlfo_pkg::RST_MAX_LEVEL;
    logic [mwlfo_pkg::MODE_W-1:0]  mode_r   = mwlfo_pkg::RST_WAVE_MODE;

    longint      quarter_sine [0:QUARTER_N];
    t_lfo_sample sample_q [$];
    int          fail_count = 0;
    int          pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    // Build the quarter-wave sine in Q30 from a truncating Taylor series to x^13
    initial begin
        longint x;
        longint x_sq;
        longint term;
        longint acc;
        for (int k = 0; k <= QUARTER_N; k++) begin
            x    = (HALF_PI_FIX * longint'(k)) / longint'(QUARTER_N);
            x_sq = (x * x) >>> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 6; n++) begin
                term = ((term * x_sq) >>> 30) / longint'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - term : acc + term;
            end
            if (acc < 0) acc = 0;
            if (acc > UNIT_Q30) acc = UNIT_Q30;
            quarter_sine[k] = acc;
        end
    end

    // Sine shape: quadrant fold, interpolated table read, truncate to Q1.16
    function automatic logic [mwlfo_pkg::SHAPE_W-1:0] sine_shape(input logic [31:0] phase);
        logic [1:0]  quad;
        logic [30:0] pos;
        logic [8:0]  idx;
        logic [21:0] frac;
        logic [63:0] slope;
        longint      s;
        longint      lo;
        longint      hi;
        quad = phase[31:30];
        pos  = {1'b0, phase[29:0]};
        if (quad[0]) pos = 31'h4000_0000 - pos;
        idx  = pos[30:22];
        frac = pos[21:0];
        if (idx >= QUARTER_N) begin
            s = quarter_sine[QUARTER_N];
        end else begin
            lo    = quarter_sine[idx];
            hi    = quarter_sine[idx + 1];
            slope = hi - lo;
            slope = slope * {42'd0, frac};
            s     = lo + longint'(slope >> 22);
        end
        if (s > UNIT_Q30) s = UNIT_Q30;
        s = quad[1] ? UNIT_Q30 - s : UNIT_Q30 + s;
        return mwlfo_pkg::SHAPE_W'(s >>> 15);
    endfunction

    // Expected sample for one tick count under the current registers
    function automatic t_lfo_sample predict_wave(input logic [31:0] ticks);
        t_lfo_sample res;
        logic [31:0] phase;
        logic [32:0] twice;
        logic [32:0] fold;
        longint      span;
        longint      lvl;
        phase = ticks * step_r + offset_r;
        case (mode_r)
            mwlfo_pkg::MODE_SINE:     res.shape = sine_shape(phase);
            mwlfo_pkg::MODE_SAW:      res.shape = {1'b0, phase[31:16]};
            mwlfo_pkg::MODE_SQUARE:   res.shape = phase[31] ? 17'h1_0000 : 17'h0_0000;
            mwlfo_pkg::MODE_TRIANGLE: begin
                twice = {phase, 1'b0};
                fold  = twice[32] ? {1'b0, twice[31:0]} : 33'h1_0000_0000 - twice;
                res.shape = fold[32:16];
            end
            default:       res.shape = 17'h0_8000;
        endcase
        span = longint'($signed(max_r)) - longint'($signed(min_r));
        lvl  = longint'($signed(min_r))
             + ((longint'(res.shape) * span) >>> mwlfo_pkg::SHAPE_FRAC_BITS);
        if (lvl > LEVEL_HI) lvl = LEVEL_HI;
        if (lvl < LEVEL_LO) lvl = LEVEL_LO;
        res.level = lvl[mwlfo_pkg::LEVEL_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_LIMIT) $display("[%0t] lfo check: %s", $time, what);
        fail_count++;
    endtask

    // Track register writes, queue predictions, compare accepted samples in order
    always @(posedge i_clk) begin : sample_watch
        t_lfo_sample want;
        logic [mwlfo_pkg::LEVEL_W-1:0] got_level;
        logic [mwlfo_pkg::SHAPE_W-1:0] got_shape;
        got_level = i_out_data[27:0];
        got_shape = i_out_data[44:28];
        if (!i_rst_n) begin
            step_r   = mwlfo_pkg::RST_PHASE_STEP;
            offset_r = mwlfo_pkg::RST_PHASE_OFFSET;
            min_r    = mwlfo_pkg::RST_MIN_LEVEL;
            max_r    = mwlfo_pkg::RST_MAX_LEVEL;
            mode_r   = mwlfo_pkg::RST_WAVE_MODE;
            sample_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mwlfo_pkg::REG_PHASE_STEP:   step_r   = i_cfg_data;
                    mwlfo_pkg::REG_PHASE_OFFSET: offset_r = i_cfg_data;
                    mwlfo_pkg::REG_MIN_LEVEL:    min_r    = i_cfg_data[mwlfo_pkg::LEVEL_W-1:0];
                    mwlfo_pkg::REG_MAX_LEVEL:    max_r    = i_cfg_data[mwlfo_pkg::LEVEL_W-1:0];
                    mwlfo_pkg::REG_WAVE_MODE:    mode_r   = i_cfg_data[mwlfo_pkg::MODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                sample_q.insert(sample_q.size(), predict_wave(i_in_time));
            if (i_out_valid && i_out_ready) begin
                if (sample_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample level=%h shape=%h",
                                              got_level, got_shape));
                end else begin
                    want = sample_q.pop_front();
                    if (got_level !== want.level)
                        report_mismatch($sformatf("level %h, expected %h",
                                                  got_level, want.level));
                    if (got_shape !== want.shape)
                        report_mismatch($sformatf("shape %h, expected %h",
                                                  got_shape, want.shape));
                    if (i_out_data[47:45] !== 3'b000)
                        report_mismatch($sformatf("padding bits %b", i_out_data[47:45]));
                end
            end
        end
        pending = sample_q.size();
    end

endmodule

### tb/sv/tb_multi_waveform_lfo.sv
// Testbench top for the multi-waveform LFO: clock, reset, stimulus, stalls and verdict.
module tb_multi_waveform_lfo;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1950;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [mwlfo_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [mwlfo_pkg::LEVEL_W-1:0]   LEVEL_TOP       = 28'h7FF_FFFF;
    localparam logic [mwlfo_pkg::LEVEL_W-1:0]   LEVEL_BOTTOM    = 28'h800_0000;
    localparam logic [mwlfo_pkg::MODE_W-1:0]    MODE_HALF_A     = 3'd4;
    localparam logic [mwlfo_pkg::MODE_W-1:0]    MODE_HALF_B     = 3'd6;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;

    int fail_count;
    int pending;
    bit tx_calm = 1'b0;

    multi_waveform_lfo uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    lfo_wave_checker wave_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_time    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin : idle_watchdog
        int idle_cycles;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_multi_waveform_lfo: errors");
            $finish;
        end
    end

    // Stall the output side: calm stretches, short random stalls, rare long ones
    always @(posedge i_clk) begin : sink_stall
        int hold_left;
        int phase_left;
        bit calm;
        int roll;
        if (phase_left == 0) begin
            calm       = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(100, 400);
        end else begin
            phase_left--;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                m_axis_tready <= 1'b1;
            end else if (roll < 97) begin
                m_axis_tready <= 1'b0;
                hold_left = $urandom_range(0, 2);
            end else begin
                m_axis_tready <= 1'b0;
                hold_left = $urandom_range(20, 80);
            end
        end
    end

    // Send one tick count after a random gap; returns at the accepting edge
    task automatic push_time(input logic [31:0] ticks);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_calm || roll < 60) gap = 0;
        else if (roll < 90) gap = $urandom_range(1, 3);
        else if (roll < 98) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ticks;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
    endtask

    // Hold the input idle until every expected sample has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mwlfo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
    endtask

    // Reprogram every register while idle; unused upper data bits are random
    task automatic set_regs(input logic [31:0] step, input logic [31:0] offset,
                            input logic [mwlfo_pkg::LEVEL_W-1:0] lo,
                            input logic [mwlfo_pkg::LEVEL_W-1:0] hi,
                            input logic [mwlfo_pkg::MODE_W-1:0] mode);
        drain();
        write_reg(REG_SPARE_FIRST + mwlfo_pkg::CFG_IDX_W'($urandom_range(0, 2)), $urandom());
        write_reg(mwlfo_pkg::REG_PHASE_STEP, step);
        write_reg(mwlfo_pkg::REG_PHASE_OFFSET, offset);
        write_reg(mwlfo_pkg::REG_MIN_LEVEL, {4'($urandom()), lo});
        write_reg(mwlfo_pkg::REG_MAX_LEVEL, {4'($urandom()), hi});
        write_reg(mwlfo_pkg::REG_WAVE_MODE, {29'($urandom()), mode});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [mwlfo_pkg::LEVEL_W-1:0] pick_level();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return LEVEL_TOP;
            1:       return LEVEL_BOTTOM;
            2, 3:    return mwlfo_pkg::LEVEL_W'($urandom_range(0, 131072) - 65536);
            default: return mwlfo_pkg::LEVEL_W'($urandom());
        endcase
    endfunction

    initial begin
        logic [31:0] corner_t [5];
        logic [31:0] step;
        logic [31:0] offset;
        logic [31:0] ticks;
        logic [mwlfo_pkg::MODE_W-1:0] mode;
        int sent;
        int burst;
        int roll;
        corner_t = '{32'h0000_0000, 32'h4000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'hFFFF_FFFF};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: slow sine, levels 0 to 65536
        push_time(32'h0000_0000);
        push_time(32'hFFFF_FFFF);

        // Each waveform across the phase corners, full level range
        for (int m = 0; m < 4; m++) begin
            set_regs(32'd1, 32'd0, LEVEL_BOTTOM, LEVEL_TOP, mwlfo_pkg::MODE_W'(m));
            foreach (corner_t[i]) push_time(corner_t[i]);
        end

        // Unused modes give a constant half
        set_regs(32'd1, 32'd0, LEVEL_BOTTOM, LEVEL_TOP, MODE_HALF_A);
        push_time(32'h1234_5678);
        set_regs(32'd1, 32'd0, LEVEL_BOTTOM, LEVEL_TOP, MODE_HALF_B);
        push_time(32'h8765_4321);

        // Reversed levels with a wrapping phase product
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, LEVEL_TOP, LEVEL_BOTTOM, mwlfo_pkg::MODE_SAW);
        push_time(32'hFFFF_FFFF);
        push_time(32'h1234_5678);

        // Random register settings, each followed by a burst of tick counts
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 19);
            if (roll < 5) step = $urandom();
            else if (roll < 10) step = $urandom_range(1, 1 << 20);
            else if (roll < 12) step = 32'd0;
            else if (roll < 14) step = 32'hFFFF_FFFF;
            else if (roll < 17) step = 32'd1 << $urandom_range(0, 31);
            else step = mwlfo_pkg::RST_PHASE_STEP;
            roll = $urandom_range(0, 9);
            if (roll < 5) offset = $urandom();
            else if (roll < 7) offset = 32'd0;
            else if (roll < 8) offset = 32'hFFFF_FFFF;
            else offset = 32'($urandom_range(0, 3)) << 30;
            roll = $urandom_range(0, 9);
            mode = (roll < 8) ? mwlfo_pkg::MODE_W'(roll % 4)
                              : mwlfo_pkg::MODE_W'($urandom_range(4, 7));
            set_regs(step, offset, pick_level(), pick_level(), mode);

            tx_calm = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(20, 120);
            repeat (burst) begin
                roll = $urandom_range(0, 19);
                if (roll < 10) ticks = $urandom();
                else if (roll < 14) ticks = $urandom_range(0, 1000);
                else if (roll < 17) ticks = 32'hFFFF_FFFF - $urandom_range(0, 1000);
                else ticks = 32'($urandom_range(0, 3)) << 30;
                push_time(ticks);
                sent++;
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_multi_waveform_lfo: clean");
        end else begin
            $display("tb_multi_waveform_lfo: errors");
        end
        $finish;
    end

endmodule

### multi_waveform_lfo.f
sv/mwlfo_pkg.sv
sv/multi_waveform_lfo.sv
tb/sv/lfo_wave_checker.sv
tb/sv/tb_multi_waveform_lfo.sv
